>>> hdl/sawlc_pkg.sv
// types and constants for the set-associative write-back lru cache tag store
// no dependencies
package sawlc_pkg;

  localparam int AddrBits = 48;

  localparam logic [1:0] CfgOffsetBits = 2'd0;
  localparam logic [1:0] CfgIndexBits  = 2'd1;
  localparam logic [1:0] CfgWaysInUse  = 2'd2;

  typedef struct packed {
    logic                req_type;
    logic [AddrBits-1:0] address;
  } in_req_t;

  typedef struct packed {
    logic                hit;
    logic [7:0]          set_index;
    logic [2:0]          way;
    logic                victim_valid;
    logic                writeback;
    logic [AddrBits-1:0] writeback_address;
  } out_res_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOOK = 2'b10
  } state_t;

endpackage

>>> hdl/sawlc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module sawlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/set_assoc_writeback_lru_cache_unit.sv
// top level of the set-associative write-back lru cache tag store
// depends on sawlc_pkg and sawlc_ram
//
// channel | direction | handshake            | payload
// in      | input     | start / busy         | in_req  (in_req_t)
// out     | output    | out_valid strobe     | out_res (out_res_t)
// cfg     | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// for each access the set row is read from the tag and state rams on
// the accept edge, then compared, updated and written back in the next cycle.
// the result strobe is registered and rises in the cycle after that; a new access may start then.
// synchronous active-low reset clears the per-set valid flags, so no clearing pass.
// the result cannot be stalled; configuration writes always transfer.
module set_assoc_writeback_lru_cache_unit
  import sawlc_pkg::*;
#(
  parameter int SETS = 256,
  parameter int WAYS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_req_t    in_req,
  output logic       out_valid,
  output out_res_t   out_res,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int RW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TW    = AddrBits - 2;
  localparam int MW    = 2 + RW;
  localparam int MAXIB = $clog2(SETS + 1) - 1;

  state_t state_r, state_nxt;
  logic [2:0] ob_cfg_r;
  logic [3:0] ib_cfg_r;
  logic [3:0] nw_cfg_r;
  logic [SETS-1:0] rowv_r;

  logic [SW-1:0]    set_r;
  logic [TW-1:0]    tag_r;
  logic [2:0]       ob_r;
  logic [4:0]       shift_r;
  logic [4:0]       nw_r;
  logic             wr_r;
  logic             out_valid_r;
  out_res_t         out_res_r, res_nxt;

  logic [2:0]          ob_c;
  logic [3:0]          ib_c;
  logic [4:0]          nw_c;
  logic [AddrBits-1:0] set_full;
  logic [SW-1:0]       set_c;
  logic [AddrBits-1:0] tag_full;
  logic                accept;

  logic [WAYS*TW-1:0] tag_rd, tag_wd;
  logic [WAYS*MW-1:0] meta_rd, meta_wd;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    ob_c = ob_cfg_r;
    if (ob_cfg_r < 3'd2) ob_c = 3'd2;
    if (ob_cfg_r > 3'd6) ob_c = 3'd6;
    ib_c = ib_cfg_r;
    if (ib_cfg_r > 4'(MAXIB)) ib_c = 4'(MAXIB);
    nw_c = {1'b0, nw_cfg_r};
    if (nw_cfg_r == 4'd0) nw_c = 5'd1;
    if ({1'b0, nw_cfg_r} > 5'(WAYS)) nw_c = 5'(WAYS);
    set_full = (in_req.address >> ob_c) & ((AddrBits'(1) << ib_c) - AddrBits'(1));
    set_c    = set_full[SW-1:0];
    tag_full = in_req.address >> ({2'b00, ob_c} + {1'b0, ib_c});
  end

  sawlc_ram #(.WIDTH(WAYS*TW), .DEPTH(SETS)) u_tag_ram (
    .clk   (clk),
    .we    (state_r == S_LOOK),
    .waddr (set_r),
    .wdata (tag_wd),
    .raddr (set_c),
    .rdata (tag_rd)
  );

  sawlc_ram #(.WIDTH(WAYS*MW), .DEPTH(SETS)) u_meta_ram (
    .clk   (clk),
    .we    (state_r == S_LOOK),
    .waddr (set_r),
    .wdata (meta_wd),
    .raddr (set_c),
    .rdata (meta_rd)
  );

  // lookup, victim choice and recency update on the row just read
  always_comb begin
    logic [WAYS-1:0]   vld;
    logic [WAYS-1:0]   drt;
    logic [RW-1:0]     rk [WAYS];
    logic              hit;
    logic [RW-1:0]     hit_way;
    logic [RW-1:0]     vic;
    logic [RW-1:0]     sel;
    logic [RW-1:0]     old_rk;
    logic [TW-1:0]     vtag;
    logic [AddrBits-1:0] wb_addr;
    logic              wb;
    hit = 1'b0;
    hit_way = '0;
    vic = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (rowv_r[set_r]) begin
        vld[w] = meta_rd[w*MW];
        drt[w] = meta_rd[w*MW+1];
        rk[w]  = meta_rd[w*MW+2 +: RW];
      end else begin
        vld[w] = 1'b0;
        drt[w] = 1'b0;
        rk[w]  = RW'(w);
      end
    end
    for (int w = WAYS-1; w >= 0; w--) begin
      if (5'(w) < nw_r && vld[w] && tag_rd[w*TW +: TW] == tag_r) begin
        hit = 1'b1;
        hit_way = RW'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (5'(w) < nw_r && rk[w] < rk[vic]) vic = RW'(w);
    end
    sel = hit ? hit_way : vic;
    old_rk = rk[sel];
    vtag = tag_rd[vic*TW +: TW];
    wb = !hit && vld[vic] && drt[vic];
    wb_addr = (({2'b00, vtag}) << shift_r) | (AddrBits'(set_r) << ob_r);
    tag_wd  = tag_rd;
    meta_wd = '0;
    for (int w = 0; w < WAYS; w++) begin
      logic          nv, nd;
      logic [RW-1:0] nr;
      nv = vld[w];
      nd = drt[w];
      nr = (rk[w] > old_rk) ? rk[w] - RW'(1) : rk[w];
      if (RW'(w) == sel) begin
        nr = RW'(WAYS - 1);
        if (hit) begin
          nd = drt[w] | wr_r;
        end else begin
          nv = 1'b1;
          nd = wr_r;
          tag_wd[w*TW +: TW] = tag_r;
        end
      end
      meta_wd[w*MW +: MW] = {nr, nd, nv};
    end
    res_nxt.hit               = hit;
    res_nxt.set_index         = 8'(set_r);
    res_nxt.way               = 3'(sel);
    res_nxt.victim_valid      = !hit && vld[vic];
    res_nxt.writeback         = wb;
    res_nxt.writeback_address = wb ? wb_addr : '0;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_LOOK;
      S_LOOK: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ob_cfg_r    <= 3'd5;
      ib_cfg_r    <= 4'd8;
      nw_cfg_r    <= 4'd8;
      rowv_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_LOOK);
      if (state_r == S_LOOK) rowv_r[set_r] <= 1'b1;
      if (cfg_valid) begin
        unique case (cfg_index)
          CfgOffsetBits: ob_cfg_r <= cfg_data[2:0];
          CfgIndexBits:  ib_cfg_r <= cfg_data;
          CfgWaysInUse:  nw_cfg_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_r   <= set_c;
      tag_r   <= tag_full[TW-1:0];
      ob_r    <= ob_c;
      shift_r <= {2'b00, ob_c} + {1'b0, ib_c};
      nw_r    <= nw_c;
      wr_r    <= in_req.req_type;
    end
    if (state_r == S_LOOK) out_res_r <= res_nxt;
  end

endmodule

>>> hdl/sawlc_checker.sv
// port-level checks for the cache tag store, bound to the top level
// depends on sawlc_pkg and set_assoc_writeback_lru_cache_unit
module sawlc_checker
  import sawlc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input out_res_t out_res
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_valid) else $error("missing result");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without access");

  a_hit_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.hit |-> !out_res.victim_valid && !out_res.writeback)
    else $error("victim on hit");

  a_wb_implies_victim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.writeback |-> out_res.victim_valid)
    else $error("write-back without victim");

endmodule

bind set_assoc_writeback_lru_cache_unit sawlc_checker u_sawlc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);

>>> sim/set_assoc_writeback_lru_cache_unit_tb.sv
// self-checking bench for the set-associative write-back lru cache tag store
// depends on sawlc_pkg and set_assoc_writeback_lru_cache_unit
// directed table then random accesses, each result checked against a behavioral cache model
module set_assoc_writeback_lru_cache_unit_tb;
  import sawlc_pkg::*;

  localparam int NSETS = 256;
  localparam int NWAYS = 8;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_req_t    in_req;
  logic       out_valid;
  out_res_t   out_res;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;

  set_assoc_writeback_lru_cache_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model state
  logic [47:0] tag_mem [NSETS*NWAYS];
  logic        vld_mem [NSETS*NWAYS];
  logic        drt_mem [NSETS*NWAYS];
  int          rank_mem [NSETS*NWAYS];
  logic [2:0]  cur_ob;
  logic [3:0]  cur_ib;
  logic [3:0]  cur_nw;

  out_res_t exp_q[$];
  int errors = 0;

  typedef struct {
    logic     wr;
    logic [47:0] addr;
    logic     chk;
    out_res_t res;
  } row_t;

  function automatic void bump_rank(int base, int w);
    int old;
    old = rank_mem[base+w];
    for (int j = 0; j < NWAYS; j++)
      if (rank_mem[base+j] > old) rank_mem[base+j]--;
    rank_mem[base+w] = NWAYS-1;
  endfunction

  function automatic out_res_t cache_lookup(logic wr, logic [47:0] addr);
    out_res_t r;
    int ob, ib, nw, shift, set, base, victim;
    logic [47:0] tag;
    ob = int'(cur_ob); ib = int'(cur_ib); nw = int'(cur_nw);
    if (ob < 2) ob = 2;
    if (ob > 6) ob = 6;
    if (ib > 8) ib = 8;
    if (nw < 1) nw = 1;
    if (nw > NWAYS) nw = NWAYS;
    shift = ob + ib;
    set = int'((addr >> ob) & ((48'd1 << ib) - 1));
    tag = addr >> shift;
    base = set * NWAYS;
    r = '0;
    r.set_index = set[7:0];
    for (int w = 0; w < nw; w++) begin
      if (vld_mem[base+w] && tag_mem[base+w] == tag) begin
        if (wr) drt_mem[base+w] = 1'b1;
        bump_rank(base, w);
        r.hit = 1'b1;
        r.way = w[2:0];
        return r;
      end
    end
    victim = 0;
    for (int w = 1; w < nw; w++)
      if (rank_mem[base+w] < rank_mem[base+victim]) victim = w;
    if (vld_mem[base+victim]) begin
      r.victim_valid = 1'b1;
      if (drt_mem[base+victim]) begin
        r.writeback = 1'b1;
        r.writeback_address = (tag_mem[base+victim] << shift) | (48'(set) << ob);
      end
    end
    tag_mem[base+victim] = tag;
    vld_mem[base+victim] = 1'b1;
    drt_mem[base+victim] = wr;
    bump_rank(base, victim);
    r.way = victim[2:0];
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("Simulation FAILED");
    $finish;
  end

  // result checker
  always @(posedge clk) begin
    out_res_t e;
    if (rst_n && out_valid) begin
      if (exp_q.size() == 0) begin
        $error("unexpected result %p", out_res);
        errors++;
      end else begin
        e = exp_q.pop_front();
        if (out_res.hit !== e.hit) begin
          $error("hit exp %0d got %0d", e.hit, out_res.hit); errors++;
        end
        if (out_res.set_index !== e.set_index) begin
          $error("set_index exp %0d got %0d", e.set_index, out_res.set_index); errors++;
        end
        if (out_res.way !== e.way) begin
          $error("way exp %0d got %0d", e.way, out_res.way); errors++;
        end
        if (out_res.victim_valid !== e.victim_valid) begin
          $error("victim_valid exp %0d got %0d", e.victim_valid, out_res.victim_valid);
          errors++;
        end
        if (out_res.writeback !== e.writeback) begin
          $error("writeback exp %0d got %0d", e.writeback, out_res.writeback); errors++;
        end
        if (out_res.writeback_address !== e.writeback_address) begin
          $error("writeback_address exp %h got %h", e.writeback_address,
                 out_res.writeback_address);
          errors++;
        end
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CfgOffsetBits: cur_ob = val[2:0];
      CfgIndexBits:  cur_ib = val;
      CfgWaysInUse:  cur_nw = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    int n;
    n = 0;
    start <= 1'b0;
    while (exp_q.size() != 0 && n < 10000) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic send_access(logic wr, logic [47:0] addr, logic chk, out_res_t res);
    out_res_t p;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req.req_type <= wr;
    in_req.address  <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = cache_lookup(wr, addr);
    if (chk && p !== res) begin
      $error("model disagrees with table row for address %h", addr);
      errors++;
    end
    exp_q.push_back(p);
  endtask

  task automatic set_cfg(logic [3:0] ob, logic [3:0] ib, logic [3:0] nw);
    drain();
    cfg_write(CfgOffsetBits, ob);
    cfg_write(CfgIndexBits, ib);
    cfg_write(CfgWaysInUse, nw);
    cfg_valid <= 1'b0;
  endtask

  function automatic out_res_t mk(logic h, logic [7:0] s, logic [2:0] w, logic vv,
                                  logic wb, logic [47:0] wa);
    out_res_t r;
    r.hit = h; r.set_index = s; r.way = w; r.victim_valid = vv;
    r.writeback = wb; r.writeback_address = wa;
    return r;
  endfunction

  initial begin
    row_t tbl[$];
    logic [47:0] pool[16];
    logic [47:0] a;
    int lo;
    rst_n = 1'b0; start = 1'b0; in_req = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    for (int i = 0; i < NSETS*NWAYS; i++) begin
      vld_mem[i] = 1'b0; drt_mem[i] = 1'b0; tag_mem[i] = '0; rank_mem[i] = i % NWAYS;
    end
    cur_ob = 3'd5; cur_ib = 4'd8; cur_nw = 4'd8;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, reset configuration
    tbl.push_back('{1'b0, 48'h0, 1'b1, mk(0, 8'd0, 3'd0, 0, 0, 48'h0)});
    tbl.push_back('{1'b0, 48'h0, 1'b1, mk(1, 8'd0, 3'd0, 0, 0, 48'h0)});
    tbl.push_back('{1'b1, 48'hFFFF_FFFF_FFFF, 1'b1, mk(0, 8'hFF, 3'd0, 0, 0, 48'h0)});
    tbl.push_back('{1'b1, 48'hFFFF_FFFF_FFE0, 1'b1, mk(1, 8'hFF, 3'd0, 0, 0, 48'h0)});
    tbl.push_back('{1'b0, 48'h0000_0000_2000, 1'b0, '0});
    tbl.push_back('{1'b1, 48'h0000_0000_4000, 1'b0, '0});
    tbl.push_back('{1'b0, 48'h0000_0000_2000, 1'b0, '0});
    tbl.push_back('{1'b0, 48'hAAAA_AAAA_AAAA, 1'b0, '0});
    tbl.push_back('{1'b1, 48'h5555_5555_5555, 1'b0, '0});
    foreach (tbl[i]) send_access(tbl[i].wr, tbl[i].addr, tbl[i].chk, tbl[i].res);

    // one way, dirty line evicted by same set
    set_cfg(4'd2, 4'd0, 4'd1);
    send_access(1'b1, 48'h0000_0000_1234, 1'b0, '0);
    send_access(1'b0, 48'h0000_0000_5678, 1'b1, mk(0, 8'd0, 3'd0, 1, 1, 48'h1234));
    // out of range registers saturate
    set_cfg(4'd7, 4'd15, 4'd0);
    send_access(1'b1, 48'h8000_0000_0040, 1'b0, '0);
    send_access(1'b1, 48'h4000_0000_0040, 1'b0, '0);
    set_cfg(4'd0, 4'd3, 4'd15);
    for (int i = 0; i < 10; i++) send_access(1'b1, 48'(i) << 5, 1'b0, '0);

    // random phases with small address pools for locality
    for (int ph = 0; ph < 10; ph++) begin
      set_cfg(4'($urandom_range(0, 7)),
              (ph % 3 == 0) ? 4'(ph % 9) : 4'($urandom_range(0, 15)),
              (ph == 1) ? 4'd8 : (ph == 2) ? 4'd1 : 4'($urandom_range(0, 15)));
      for (int i = 0; i < 16; i++) begin
        pool[i] = 48'({$urandom(), $urandom()});
        if ($urandom_range(0, 1)) pool[i][47:12] = 36'($urandom_range(0, 3));
      end
      for (int i = 0; i < 75; i++) begin
        lo = $urandom_range(0, 9);
        if (lo < 8) a = pool[$urandom_range(0, 15)] ^ 48'($urandom_range(0, 63));
        else a = 48'({$urandom(), $urandom()});
        send_access(1'($urandom_range(0, 1)), a, 1'b0, '0);
      end
    end

    drain();
    if (exp_q.size() != 0) begin
      $error("%0d results never arrived", exp_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> set_assoc_writeback_lru_cache_unit.f
hdl/sawlc_pkg.sv
hdl/sawlc_ram.sv
hdl/set_assoc_writeback_lru_cache_unit.sv
hdl/sawlc_checker.sv
sim/set_assoc_writeback_lru_cache_unit_tb.sv
